/* rtl/core/pcmmix_pkg.sv */
// Package with shared types and constants for the multichannel PCM sample mixer.
package pcmmix_pkg;

   localparam int Channels       = 8;
   localparam int ChanBits       = 3;
   localparam int MemAddrBits    = 16;
   localparam int ReqDataBits    = 120;
   localparam int RspDataBits    = 40;
   localparam logic [23:0] OneQ16 = 24'h010000;

   typedef enum logic [2:0] {
      MODE_TICK  = 3'd0,
      MODE_WRITE = 3'd1,
      MODE_PLAY  = 3'd2,
      MODE_STOP  = 3'd3,
      MODE_GAINS = 3'd4,
      MODE_PITCH = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAYG,
      ST_PLAYR,
      ST_PLAYE,
      ST_CHECK,
      ST_STEP,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_MULL,
      ST_MULR,
      ST_NEXT,
      ST_OUT
   } state_type;

   // Shared multiplier operation select.
   typedef enum logic [1:0] {
      MUL_GAIN_L,
      MUL_GAIN_R,
      MUL_PITCH,
      MUL_SAMPLE
   } mulsel_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) r = 16'sd32767;
      else if (v < -18'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
   endfunction

endpackage

/* rtl/core/pcmmix_mul.sv */
// Shared registered multiplier used by every multiplication of the mixer.
module pcmmix_mul
   import pcmmix_pkg::*;
(
   input  logic               clock,
   input  logic signed [24:0] a,
   input  logic signed [24:0] b,
   output logic signed [49:0] p
);

   logic signed [49:0] p_ff;
   logic signed [49:0] p_in;

   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

/* rtl/core/pcmmix_mem.sv */
// Byte-wide sample memory with one write port and one registered read port.
module pcmmix_mem
   import pcmmix_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [MemAddrBits-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic [MemAddrBits-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [2**MemAddrBits];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

/* rtl/core/multichannel_pcm_sample_mixer.sv */
// Top level of the multichannel PCM sample mixer: sequencer, channel state and output register.
// A nonzero-length play passes PLAYG, PLAYR and PLAYE to form both gain products; other
// commands but tick finish in the idle state. A tick walks the channels one at a time through
// one shared multiplier: an idle or ended channel visits CHECK, NEXT; a muted one CHECK, STEP,
// NEXT; an audible one CHECK, RD0-RD2, MULL, MULR, NEXT. Throughput is one item at a time;
// req_tready is low while an item is at work or a result is held. Synchronous active-high
// reset idles all channels and clears loop_mask; sample memory is not cleared.
module multichannel_pcm_sample_mixer
   import pcmmix_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode[2:0], channel[5:3], address[21:6], data_byte[29:22], frame_count[45:30],
   // level_a[60:46], level_b[75:61], pan[91:76], pitch[115:92], wide_samples[116]
   input  logic [ReqDataBits-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // left_sample[15:0], right_sample[31:16], active_mask[39:32]
   output logic [RspDataBits-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata
);

   mode_type   req_mode;
   logic [2:0] req_chan;
   logic [15:0] req_addr, req_count, req_pan_raw;
   logic [7:0] req_byte;
   logic [14:0] req_la, req_lb;
   logic [23:0] req_pitch;
   logic       req_wide;

   assign req_mode    = mode_type'(req_tdata[2:0]);
   assign req_chan    = req_tdata[5:3];
   assign req_addr    = req_tdata[21:6];
   assign req_byte    = req_tdata[29:22];
   assign req_count   = req_tdata[45:30];
   assign req_la      = req_tdata[60:46];
   assign req_lb      = req_tdata[75:61];
   assign req_pan_raw = req_tdata[91:76];
   assign req_pitch   = req_tdata[115:92];
   assign req_wide    = req_tdata[116];

   logic [15:0] start_ff [Channels];
   logic [15:0] len_ff   [Channels];
   logic [31:0] pos_ff   [Channels];
   logic [23:0] bpitch_ff[Channels];
   logic [23:0] gpitch_ff[Channels];
   logic [14:0] gl_ff    [Channels];
   logic [14:0] gr_ff    [Channels];
   logic [Channels-1:0] wide_ff;
   logic [Channels-1:0] act_ff, act_in;
   logic [7:0]  loop_ff;

   state_type state_ff, state_in;
   logic [ChanBits-1:0] ch_ff;
   logic [14:0] la_ff;
   logic signed [16:0] panp_ff, panm_ff;
   logic signed [15:0] l_ff, r_ff, smp_ff;
   logic [7:0] hi_ff;
   logic [39:0] out_ff;
   logic out_v_ff;
   logic mulr_ff;
   logic accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   // Shared multiplier.
   mulsel_type sel;
   logic signed [24:0] ma, mb;
   logic signed [49:0] mp;

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (sel)
         MUL_GAIN_L: begin ma = {10'd0, la_ff}; mb = 25'(panm_ff); end
         MUL_GAIN_R: begin ma = {10'd0, la_ff}; mb = 25'(panp_ff); end
         MUL_PITCH:  begin ma = {1'b0, bpitch_ff[ch_ff]}; mb = {1'b0, gpitch_ff[ch_ff]}; end
         MUL_SAMPLE: begin
            ma = 25'(smp_ff);
            mb = (state_ff == ST_MULR) ? {10'd0, gr_ff[ch_ff]} : {10'd0, gl_ff[ch_ff]};
         end
         default: ;
      endcase
   end

   pcmmix_mul u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   // Sample memory access.
   logic [15:0] frame_idx, rd_addr, base_addr;
   logic [7:0]  rd_data;
   logic        mem_we;

   assign frame_idx = pos_ff[ch_ff][31:16];
   assign base_addr = wide_ff[ch_ff] ? start_ff[ch_ff] + {frame_idx[14:0], 1'b0}
                                     : start_ff[ch_ff] + frame_idx;
   assign rd_addr   = (state_ff == ST_RD1) ? base_addr + 16'd1 : base_addr;
   assign mem_we    = accept && (req_mode == MODE_WRITE);

   pcmmix_mem u_mem (.clock(clock), .wr_en(mem_we), .wr_addr(req_addr), .wr_data(req_byte),
                     .rd_addr(rd_addr), .rd_data(rd_data));

   logic muted, at_end, loops;
   logic [31:0] step;
   logic [31:0] stepraw;

   assign muted   = (gl_ff[ch_ff] == '0) && (gr_ff[ch_ff] == '0);
   assign at_end  = frame_idx >= len_ff[ch_ff];
   assign loops   = loop_ff[ch_ff];
   assign stepraw = mp[47:16];
   assign step    = (stepraw == '0) ? 32'h0001_0000 : stepraw;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_TICK) state_in = ST_CHECK;
            else if (accept && req_mode == MODE_PLAY && req_count != '0) state_in = ST_PLAYG;
         end
         ST_PLAYG: state_in = ST_PLAYR;
         ST_PLAYR: state_in = ST_PLAYE;
         ST_PLAYE: state_in = ST_IDLE;
         ST_CHECK: begin
            if (!act_ff[ch_ff]) state_in = ST_NEXT;
            else if (muted) state_in = ST_STEP;
            else if (at_end && !loops) state_in = ST_NEXT;
            else state_in = ST_RD0;
         end
         ST_STEP: state_in = ST_NEXT;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_MULL;
         ST_MULL: state_in = ST_MULR;
         ST_MULR: state_in = ST_NEXT;
         ST_NEXT: state_in = (ch_ff == ChanBits'(Channels - 1)) ? ST_OUT : ST_CHECK;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Multiplier operand select.
   always_comb begin
      unique case (state_ff)
         ST_PLAYG: sel = MUL_GAIN_L;
         ST_PLAYR: sel = MUL_GAIN_R;
         ST_MULL, ST_MULR: sel = MUL_SAMPLE;
         default:  sel = MUL_PITCH;
      endcase
   end

   logic [16:0] g_clamp;
   logic signed [31:0] prod_sh;

   always_comb begin
      g_clamp = mp[32:16];
      if (g_clamp > 17'd32767) g_clamp = 17'd32767;
      prod_sh = mp[46:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= '0;
         loop_ff  <= '0;
         out_v_ff <= 1'b0;
         mulr_ff  <= 1'b0;
         ch_ff    <= '0;
         for (int i = 0; i < Channels; i++) begin
            bpitch_ff[i] <= OneQ16;
            gpitch_ff[i] <= OneQ16;
            gl_ff[i] <= '0;
            gr_ff[i] <= '0;
            pos_ff[i] <= '0;
            len_ff[i] <= '0;
            start_ff[i] <= '0;
         end
         wide_ff <= '0;
      end else begin
         state_ff <= state_in;
         mulr_ff  <= (state_ff == ST_MULR);
         if (csr_we) loop_ff <= csr_wdata;
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ch_ff <= (req_mode == MODE_TICK) ? '0 : req_chan;
                  la_ff <= req_la;
                  l_ff <= '0;
                  r_ff <= '0;
                  unique case (req_mode)
                     MODE_TICK: ;
                     MODE_PLAY: if (req_count != '0) begin
                        start_ff[req_chan]  <= req_addr;
                        len_ff[req_chan]    <= req_count;
                        pos_ff[req_chan]    <= '0;
                        bpitch_ff[req_chan] <= (req_pitch == '0) ? OneQ16 : req_pitch;
                        gpitch_ff[req_chan] <= OneQ16;
                        wide_ff[req_chan]   <= req_wide;
                        act_ff[req_chan]    <= 1'b1;
                     end
                     MODE_STOP:  act_ff[req_chan] <= 1'b0;
                     MODE_GAINS: begin
                        gl_ff[req_chan] <= req_la;
                        gr_ff[req_chan] <= req_lb;
                     end
                     MODE_PITCH: gpitch_ff[req_chan] <= (req_pitch == '0) ? OneQ16 : req_pitch;
                     default: ;
                  endcase
               end
               if (req_pan_raw == 16'h8000) begin
                  panm_ff <= 17'sd65535;
                  panp_ff <= 17'sd1;
               end else begin
                  panm_ff <= 17'sd32768 - 17'(signed'(req_pan_raw));
                  panp_ff <= 17'sd32768 + 17'(signed'(req_pan_raw));
               end
            end
            ST_PLAYG: ;
            ST_PLAYR: gl_ff[ch_ff] <= g_clamp[14:0];
            ST_PLAYE: gr_ff[ch_ff] <= g_clamp[14:0];
            ST_CHECK: begin
               if (act_ff[ch_ff] && !muted && at_end) begin
                  if (loops) pos_ff[ch_ff] <= '0;
                  else act_ff[ch_ff] <= 1'b0;
               end
            end
            ST_STEP: begin
               if ((pos_ff[ch_ff] + step) >> 16 >= {16'd0, len_ff[ch_ff]}) begin
                  if (loops) pos_ff[ch_ff] <= '0;
                  else begin
                     pos_ff[ch_ff] <= pos_ff[ch_ff] + step;
                     act_ff[ch_ff] <= 1'b0;
                  end
               end else pos_ff[ch_ff] <= pos_ff[ch_ff] + step;
            end
            ST_RD0: ;
            ST_RD1: hi_ff <= rd_data;
            ST_RD2: begin
               smp_ff <= wide_ff[ch_ff] ? {hi_ff, rd_data}
                                        : {hi_ff - 8'd128, 8'd0};
               pos_ff[ch_ff] <= pos_ff[ch_ff] + step;
            end
            ST_MULL: ;
            ST_MULR: l_ff <= sat16(18'(l_ff) + 18'(prod_sh));
            ST_NEXT: begin
               if (mulr_ff)
                  r_ff <= sat16(18'(r_ff) + 18'(prod_sh));
               ch_ff <= ch_ff + 1'b1;
            end
            ST_OUT: begin
               out_ff   <= {act_ff, r_ff, l_ff};
               out_v_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   property p_busy_no_ready;
      @(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> !req_tready;
   endproperty
   a_busy_no_ready: assert property (p_busy_no_ready) else $error("ready while busy");

   property p_out_after_walk;
      @(posedge clock) disable iff (reset) $rose(out_v_ff) |-> $past(state_ff) == ST_OUT;
   endproperty
   a_out_after_walk: assert property (p_out_after_walk) else $error("stray result");

   property p_hold;
      @(posedge clock) disable iff (reset) (out_v_ff && !rsp_tready) |=> out_v_ff;
   endproperty
   a_hold: assert property (p_hold) else $error("result dropped");

endmodule
